// File: design/osel_pkg.sv
// osel_pkg: payload structs, constants and the sequence crc function for the slot selector
// no dependencies; imported by ota_slot_selector_core and osel_checker
`timescale 1ns / 1ps

package osel_pkg;

    localparam logic [31:0] CRC_POLY          = 32'hedb88320;
    localparam logic [31:0] SEQ_BLANK         = 32'hffffffff;
    localparam logic [31:0] STATE_BAD_A       = 32'd3;
    localparam logic [31:0] STATE_BAD_B       = 32'd4;
    localparam logic [31:0] VALID_STATE_RESET = 32'd2;
    localparam logic [7:0]  SLOT_LIMIT        = 8'd2;

    localparam logic MODE_QUERY     = 1'b0;
    localparam logic MODE_SELECT    = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] seq_a;
        logic [31:0] check_a;
        logic [31:0] state_a;
        logic [31:0] seq_b;
        logic [31:0] check_b;
        logic [31:0] state_b;
        logic [7:0]  wanted_slot;
    } osel_in_t;

    typedef struct packed {
        logic        status;
        logic        active_slot;
        logic        a_valid;
        logic        b_valid;
        logic        dest_record;
        logic [31:0] new_seq;
        logic [31:0] new_state;
        logic [31:0] new_check;
    } osel_out_t;

    typedef logic [31:0][31:0] osel_crc_cols_t;

    // response of the crc register to each single input bit, worked out at elaboration
    function automatic osel_crc_cols_t osel_build_cols();
        osel_crc_cols_t cols;
        logic [31:0]    r;
        for (int p = 0; p < 32; p++)
        begin
            r = 32'h1 << p;
            for (int s = 0; s < 32; s++)
            begin
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            end
            cols[p] = r;
        end
        return cols;
    endfunction

    localparam osel_crc_cols_t CRC_COLS = osel_build_cols();

    // crc of the four sequence bytes, low byte first, zero start, inverted result
    function automatic logic [31:0] osel_seq_crc(input logic [31:0] seq);
        logic [31:0] r;
        r = '0;
        for (int p = 0; p < 32; p++)
        begin
            if (seq[p])
            begin
                r = r ^ CRC_COLS[p];
            end
        end
        return ~r;
    endfunction

endpackage

// File: design/ota_slot_selector_core.sv
// ota_slot_selector_core: a/b boot record check and slot selection, two-stage pipeline
// depends on osel_pkg for payload structs, constants and the crc function
`timescale 1ns / 1ps

// One result per input transaction. An accepted transaction sits in the input register,
// the record checks, slot choice, sequence increment and both crc trees are worked out in
// a single pass and the result lands in the output register once that register may advance;
// one transaction per cycle is sustained while out_ready stays high, limited only by the
// logic between the input register and the result register. in_ready stays high while the
// output is stalled until the input register also holds a transaction. cfg_we writes
// valid_state_code (reset value 2) at once; write it only while the block is empty.
module ota_slot_selector_core
    import osel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  osel_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output osel_out_t   out_data
);

    logic [31:0] vsc_code_reg;
    logic [31:0] vsc_code_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    osel_in_t    s1_data_reg;
    osel_in_t    s1_data_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    osel_out_t   out_data_reg;
    osel_out_t   out_data_next;

    logic        out_adv;
    logic        a_ok;
    logic        b_ok;
    logic [31:0] top_seq;
    logic [31:0] s0_seq;
    logic [31:0] high_seq;
    logic [31:0] step;
    logic [31:0] nseq;
    osel_out_t   res;

    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_adv;

    assign vsc_code_next = cfg_we ? cfg_wdata : vsc_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsc_code_reg <= VALID_STATE_RESET;
        end
        else
        begin
            vsc_code_reg <= vsc_code_next;
        end
    end

    // record checks
    always_comb
    begin
        a_ok = (s1_data_reg.seq_a != SEQ_BLANK)
            && (s1_data_reg.check_a == osel_seq_crc(s1_data_reg.seq_a))
            && (s1_data_reg.state_a != STATE_BAD_A)
            && (s1_data_reg.state_a != STATE_BAD_B);
        b_ok = (s1_data_reg.seq_b != SEQ_BLANK)
            && (s1_data_reg.check_b == osel_seq_crc(s1_data_reg.seq_b))
            && (s1_data_reg.state_b != STATE_BAD_A)
            && (s1_data_reg.state_b != STATE_BAD_B);
    end

    // slot choice and new record
    always_comb
    begin
        if (a_ok && b_ok)
        begin
            top_seq = (s1_data_reg.seq_a >= s1_data_reg.seq_b) ? s1_data_reg.seq_a
                                                               : s1_data_reg.seq_b;
        end
        else
        begin
            top_seq = a_ok ? s1_data_reg.seq_a : s1_data_reg.seq_b;
        end
        s0_seq   = a_ok ? s1_data_reg.seq_a : '0;
        high_seq = (b_ok && (s1_data_reg.seq_b >= s0_seq)) ? s1_data_reg.seq_b : s0_seq;
        step     = (high_seq[0] != s1_data_reg.wanted_slot[0]) ? 32'd2 : 32'd1;
        nseq     = high_seq + step;

        res             = '0;
        res.status      = STATUS_OK;
        res.active_slot = (a_ok || b_ok) ? ~top_seq[0] : 1'b0;
        res.a_valid     = a_ok;
        res.b_valid     = b_ok;
        if (s1_data_reg.mode == MODE_SELECT)
        begin
            if (s1_data_reg.wanted_slot >= SLOT_LIMIT)
            begin
                res.status = STATUS_REFUSED;
            end
            else
            begin
                res.dest_record = (high_seq == s0_seq);
                res.new_seq     = nseq;
                res.new_state   = vsc_code_reg;
                res.new_check   = osel_seq_crc(nseq);
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_data_next   = s1_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
            if (in_valid)
            begin
                s1_data_next = in_data;
            end
        end
        if (out_adv)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/osel_checker.sv
// osel_checker: port-level assertions for ota_slot_selector_core, bound to that module
// depends on osel_pkg for payload structs, constants and the crc function
`timescale 1ns / 1ps

module osel_checker
    import osel_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input osel_out_t   out_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // refused select carries no new record
    a_refused_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_REFUSED) |->
            !out_data.dest_record && (out_data.new_seq == '0)
            && (out_data.new_state == '0) && (out_data.new_check == '0))
        else $error("refused select with nonzero record fields");

    // no valid record means slot 0 active
    a_none_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.a_valid && !out_data.b_valid |-> !out_data.active_slot)
        else $error("active slot set with no valid record");

    // new check word matches new sequence
    a_new_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.new_seq != '0) |->
            out_data.new_check == osel_seq_crc(out_data.new_seq))
        else $error("new check word does not match new sequence");

endmodule

bind ota_slot_selector_core osel_checker u_osel_checker (.*);
